[hdl/srot_pkg.sv]
package srot_pkg;

  typedef struct packed {
    logic signed [23:0] lateral_offset;
    logic signed [23:0] vertical_offset;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [23:0] north;
    logic signed [23:0] east;
    logic signed [23:0] down;
    logic               last_out;
  } result_t;

  // Q.30 matrix entry, one bit of headroom over a sum of two products
  typedef logic signed [34:0] rot_ent_t;
  typedef rot_ent_t [8:0] rot_mat_t;

  // Q.30 working value inside the angle unit
  typedef logic signed [33:0] trig_t;

  localparam logic [2:0] REG_ROLL     = 3'd0;
  localparam logic [2:0] REG_PITCH    = 3'd1;
  localparam logic [2:0] REG_HEADING  = 3'd2;
  localparam logic [2:0] REG_LEV_FWD  = 3'd3;
  localparam logic [2:0] REG_LEV_LAT  = 3'd4;
  localparam logic [2:0] REG_LEV_VERT = 3'd5;

  localparam logic signed [15:0] LEV_FWD_RESET  = -16'sd705;
  localparam logic signed [15:0] LEV_LAT_RESET  = 16'sd7;
  localparam logic signed [15:0] LEV_VERT_RESET = -16'sd62;

  localparam trig_t Q30_HALF_PI  = 34'sd1686629713;
  localparam trig_t Q30_PI       = 34'sd3373259426;
  localparam trig_t CORDIC_START = 34'sd652032874;
  localparam int    MAX_STEPS    = 24;

  localparam trig_t ATAN_Q30 [MAX_STEPS] = '{
    34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
    34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
    34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
    34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
    34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F
  };

  localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] OUT_MIN = -24'sh800000;

endpackage

[hdl/srot_cordic.sv]
module srot_cordic import srot_pkg::*; #(
  parameter int ITERS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] angle,
  output logic               done,
  output trig_t              cos_out,
  output trig_t              sin_out
);

  localparam int Steps = (ITERS > MAX_STEPS) ? MAX_STEPS : ITERS;
  localparam int CW    = $clog2(Steps + 1);

  trig_t          x;
  trig_t          y;
  trig_t          z;
  logic           neg;
  logic           run;
  logic [CW-1:0]  cnt;
  logic [4:0]     idx;
  trig_t          z0;
  trig_t          dx;
  trig_t          dy;

  assign idx = 5'(cnt);
  assign z0  = 34'(angle) <<< 17;
  assign dx  = y >>> idx;
  assign dy  = x >>> idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x   <= CORDIC_START;
        y   <= '0;
        cnt <= '0;
        run <= 1'b1;
        // fold into the right half-plane, flip the signs back at the end
        if (z0 > Q30_HALF_PI) begin
          z   <= z0 - Q30_PI;
          neg <= 1'b1;
        end else if (z0 < -Q30_HALF_PI) begin
          z   <= z0 + Q30_PI;
          neg <= 1'b1;
        end else begin
          z   <= z0;
          neg <= 1'b0;
        end
      end else if (run) begin
        if (z >= 0) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - ATAN_Q30[idx];
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + ATAN_Q30[idx];
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(Steps - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign cos_out = neg ? -x : x;
  assign sin_out = neg ? -y : y;

endmodule

[hdl/srot_matrix.sv]
module srot_matrix import srot_pkg::*; #(
  parameter int ITERS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] roll,
  input  logic signed [15:0] pitch,
  input  logic signed [15:0] heading,
  output logic               busy,
  output rot_mat_t           rot
);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_GO   = 3'd1;
  localparam logic [2:0] M_WAIT = 3'd2;
  localparam logic [2:0] M_MUL  = 3'd3;
  localparam logic [2:0] M_WB   = 3'd4;
  localparam logic [2:0] M_SUM  = 3'd5;

  localparam logic [1:0] ANG_ROLL    = 2'd0;
  localparam logic [1:0] ANG_PITCH   = 2'd1;
  localparam logic [1:0] ANG_HEADING = 2'd2;
  localparam logic [3:0] LAST_STEP   = 4'd14;

  localparam logic signed [67:0] RND_HALF = 68'sd536870912;

  logic [2:0]          state;
  logic [1:0]          ang_sel;
  logic [3:0]          step;
  logic                again;
  logic signed [15:0]  ang;
  logic                c_done;
  trig_t               c_cos;
  trig_t               c_sin;
  trig_t               cr, sr, cp, sp, ch, sh;
  trig_t               r0, r3, r7, r8;
  trig_t               t0, t1, t2, t3, t4, t5, t6, t7;
  trig_t               op_a;
  trig_t               op_b;
  logic signed [67:0]  prod;
  logic signed [67:0]  prod_rnd;
  trig_t               qres;

  always_comb begin
    case (ang_sel)
      ANG_ROLL:  ang = roll;
      ANG_PITCH: ang = pitch;
      default:   ang = heading;
    endcase
  end

  srot_cordic #(.ITERS(ITERS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (state == M_GO),
    .angle   (ang),
    .done    (c_done),
    .cos_out (c_cos),
    .sin_out (c_sin)
  );

  // operand schedule for the shared multiplier
  always_comb begin
    case (step)
      4'd0:    begin op_a = ch; op_b = cp; end
      4'd1:    begin op_a = sh; op_b = cr; end
      4'd2:    begin op_a = ch; op_b = sp; end
      4'd3:    begin op_a = t1; op_b = sr; end
      4'd4:    begin op_a = sh; op_b = sr; end
      4'd5:    begin op_a = ch; op_b = cr; end
      4'd6:    begin op_a = t3; op_b = sp; end
      4'd7:    begin op_a = sh; op_b = cp; end
      4'd8:    begin op_a = sr; op_b = sp; end
      4'd9:    begin op_a = t5; op_b = sh; end
      4'd10:   begin op_a = ch; op_b = sr; end
      4'd11:   begin op_a = sp; op_b = sh; end
      4'd12:   begin op_a = t7; op_b = cr; end
      4'd13:   begin op_a = cp; op_b = sr; end
      default: begin op_a = cp; op_b = cr; end
    endcase
  end

  assign prod_rnd = prod + RND_HALF;
  assign qres     = 34'(prod_rnd >>> 30);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= M_GO;
      ang_sel <= ANG_ROLL;
      step    <= '0;
      again   <= 1'b0;
    end else begin
      // remember an angle write that lands during a rebuild
      if (start && state != M_IDLE) again <= 1'b1;
      case (state)
        M_IDLE: begin
          if (start || again) begin
            state   <= M_GO;
            ang_sel <= ANG_ROLL;
            again   <= 1'b0;
          end
        end
        M_GO: state <= M_WAIT;
        M_WAIT: begin
          if (c_done) begin
            case (ang_sel)
              ANG_ROLL:  begin cr <= c_cos; sr <= c_sin; end
              ANG_PITCH: begin cp <= c_cos; sp <= c_sin; end
              default:   begin ch <= c_cos; sh <= c_sin; end
            endcase
            if (ang_sel == ANG_HEADING) begin
              state <= M_MUL;
              step  <= '0;
            end else begin
              ang_sel <= ang_sel + 2'd1;
              state   <= M_GO;
            end
          end
        end
        M_MUL: begin
          prod  <= op_a * op_b;
          state <= M_WB;
        end
        M_WB: begin
          case (step)
            4'd0:    r0 <= qres;
            4'd1:    t0 <= qres;
            4'd2:    t1 <= qres;
            4'd3:    t1 <= qres;
            4'd4:    t2 <= qres;
            4'd5:    t3 <= qres;
            4'd6:    t4 <= qres;
            4'd7:    r3 <= qres;
            4'd8:    t5 <= qres;
            4'd9:    t5 <= qres;
            4'd10:   t6 <= qres;
            4'd11:   t7 <= qres;
            4'd12:   t7 <= qres;
            4'd13:   r7 <= qres;
            default: r8 <= qres;
          endcase
          if (step == LAST_STEP) begin
            state <= M_SUM;
          end else begin
            step  <= step + 4'd1;
            state <= M_MUL;
          end
        end
        M_SUM: begin
          rot[0] <= 35'(r0);
          rot[1] <= 35'(t1) - 35'(t0);
          rot[2] <= 35'(t2) + 35'(t4);
          rot[3] <= 35'(r3);
          rot[4] <= 35'(t3) + 35'(t5);
          rot[5] <= 35'(t7) - 35'(t6);
          rot[6] <= -35'(sp);
          rot[7] <= 35'(r7);
          rot[8] <= 35'(r8);
          state  <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  assign busy = (state != M_IDLE) || again;

endmodule

[hdl/srot_pipe.sv]
module srot_pipe import srot_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               hold,
  input  rot_mat_t           rot,
  input  logic signed [15:0] lev_fwd,
  input  logic signed [15:0] lev_lat,
  input  logic signed [15:0] lev_vert,
  input  logic               in_valid,
  output logic               in_stall,
  input  point_t             in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output result_t            out_item
);

  localparam logic signed [61:0] RND_HALF = 62'sd536870912;

  logic               en1, en2, en3, accept;
  logic               v1, v2;
  logic signed [24:0] by1, bz1;
  logic               last1, last2;
  logic signed [59:0] p [9];
  logic signed [61:0] acc [3];
  logic signed [31:0] rnd [3];
  logic signed [23:0] sat [3];

  assign en3      = !out_valid || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = hold || !en1;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 62'(p[3*r]) + 62'(p[3*r+1]) + 62'(p[3*r+2]) + RND_HALF;
      rnd[r] = acc[r][61:30];
      if (rnd[r] > 32'(OUT_MAX)) begin
        sat[r] = OUT_MAX;
      end else if (rnd[r] < 32'(OUT_MIN)) begin
        sat[r] = OUT_MIN;
      end else begin
        sat[r] = rnd[r][23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= accept;
      if (en2) v2 <= v1;
      if (en3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      by1   <= 25'(in_item.lateral_offset) + 25'(lev_lat);
      bz1   <= 25'(in_item.vertical_offset) + 25'(lev_vert);
      last1 <= in_item.last_point;
    end
    if (en2) begin
      for (int r = 0; r < 3; r++) begin
        p[3*r]   <= rot[3*r] * lev_fwd;
        p[3*r+1] <= rot[3*r+1] * by1;
        p[3*r+2] <= rot[3*r+2] * bz1;
      end
      last2 <= last1;
    end
    if (en3) begin
      out_item.north    <= sat[0];
      out_item.east     <= sat[1];
      out_item.down     <= sat[2];
      out_item.last_out <= last2;
    end
  end

endmodule

[hdl/sonar_point_body_to_ned_rotation.sv]
// Channel   Direction  Handshake                    Payload
// point     in         point_valid / point_stall    point_t
// result    out        result_valid / result_stall  result_t
// config    in         APB, psel/penable/pwrite     6 regs of 16 bits at 4*i
//
// One point per cycle while point_stall is low; each accepted point passes the
// offset, product and output registers before it appears as a result. The
// rotation matrix is rebuilt by one shared CORDIC and one shared multiplier
// after reset and after every angle write, and point_stall is high during a
// rebuild. An angle write that lands during a rebuild queues one more full rebuild.
// A stalled result holds in the output register; the two stages before it
// keep filling, then point_stall rises.
module sonar_point_body_to_ned_rotation import srot_pkg::*; #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        point_valid,
  output logic        point_stall,
  input  point_t      point,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  logic signed [15:0] roll, pitch, heading, lev_fwd, lev_lat, lev_vert;
  logic               wr;
  logic [2:0]         idx;
  logic               busy;
  rot_mat_t           rot;
  logic signed [15:0] rd;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      roll     <= '0;
      pitch    <= '0;
      heading  <= '0;
      lev_fwd  <= LEV_FWD_RESET;
      lev_lat  <= LEV_LAT_RESET;
      lev_vert <= LEV_VERT_RESET;
    end else if (wr) begin
      case (idx)
        REG_ROLL:     roll     <= pwdata[15:0];
        REG_PITCH:    pitch    <= pwdata[15:0];
        REG_HEADING:  heading  <= pwdata[15:0];
        REG_LEV_FWD:  lev_fwd  <= pwdata[15:0];
        REG_LEV_LAT:  lev_lat  <= pwdata[15:0];
        REG_LEV_VERT: lev_vert <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROLL:     rd = roll;
      REG_PITCH:    rd = pitch;
      REG_HEADING:  rd = heading;
      REG_LEV_FWD:  rd = lev_fwd;
      REG_LEV_LAT:  rd = lev_lat;
      REG_LEV_VERT: rd = lev_vert;
      default:      rd = '0;
    endcase
  end

  assign prdata = 32'(rd);

  srot_matrix #(.ITERS(TRIG_ITERATIONS)) u_matrix (
    .clk     (clk),
    .rst     (rst),
    .start   (wr && (idx == REG_ROLL || idx == REG_PITCH || idx == REG_HEADING)),
    .roll    (roll),
    .pitch   (pitch),
    .heading (heading),
    .busy    (busy),
    .rot     (rot)
  );

  srot_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .hold      (busy),
    .rot       (rot),
    .lev_fwd   (lev_fwd),
    .lev_lat   (lev_lat),
    .lev_vert  (lev_vert),
    .in_valid  (point_valid),
    .in_stall  (point_stall),
    .in_item   (point),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_item  (result)
  );

endmodule

[tb/sv/sonar_point_body_to_ned_rotation_tb.sv]
module sonar_point_body_to_ned_rotation_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srot_pkg::*;

  localparam int TRIG_STEPS = 16;
  localparam int NUM_REGS = 6;
  localparam int STALL_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic point_valid = 1'b0;
  logic point_stall;
  point_t point = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  sonar_point_body_to_ned_rotation #(.TRIG_ITERATIONS(TRIG_STEPS)) dut (.*);

  always #5 clk = ~clk;

  // shadow registers and derived rotation matrix
  logic signed [15:0] regs [NUM_REGS];
  longint rot [9];

  point_t pending_points [$];
  result_t ned_expected [$];
  int errors = 0;
  int n_points = 0, n_results = 0, n_sat = 0, n_writes = 0;
  bit tx_idle = 1'b0, rx_idle = 1'b0;
  int rx_hold = 0;
  int tx_gap = 0, rx_gap = 0, quiet_cycles = 0;

  function automatic longint rnd_shr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rnd_shr(a * b, 30);
  endfunction

  task automatic sincos(input logic signed [15:0] ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    int steps;
    z = longint'(ang) * 131072;
    x = longint'(CORDIC_START);
    y = 0;
    flip = 1'b0;
    steps = (TRIG_STEPS > MAX_STEPS) ? MAX_STEPS : TRIG_STEPS;
    if (z > longint'(Q30_HALF_PI)) begin
      z -= longint'(Q30_PI);
      flip = 1'b1;
    end else if (z < -longint'(Q30_HALF_PI)) begin
      z += longint'(Q30_PI);
      flip = 1'b1;
    end
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_Q30[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_Q30[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic rebuild_rotation();
    longint cr, sr, cp, sp, ch, sh;
    sincos(regs[REG_ROLL], cr, sr);
    sincos(regs[REG_PITCH], cp, sp);
    sincos(regs[REG_HEADING], ch, sh);
    rot[0] = qmul(ch, cp);
    rot[1] = -qmul(sh, cr) + qmul(qmul(ch, sp), sr);
    rot[2] = qmul(sh, sr) + qmul(qmul(ch, cr), sp);
    rot[3] = qmul(sh, cp);
    rot[4] = qmul(ch, cr) + qmul(qmul(sr, sp), sh);
    rot[5] = -qmul(ch, sr) + qmul(qmul(sp, sh), cr);
    rot[6] = -sp;
    rot[7] = qmul(cp, sr);
    rot[8] = qmul(cp, cr);
  endtask

  function automatic result_t rotate_point(point_t p);
    result_t r;
    longint v [3];
    longint acc, bx, by, bz;
    bx = longint'(regs[REG_LEV_FWD]);
    by = longint'(p.lateral_offset) + longint'(regs[REG_LEV_LAT]);
    bz = longint'(p.vertical_offset) + longint'(regs[REG_LEV_VERT]);
    for (int k = 0; k < 3; k++) begin
      acc = rnd_shr(rot[3*k] * bx + rot[3*k+1] * by + rot[3*k+2] * bz, 30);
      if (acc > longint'(OUT_MAX)) acc = longint'(OUT_MAX);
      if (acc < longint'(OUT_MIN)) acc = longint'(OUT_MIN);
      v[k] = acc;
    end
    r.north = v[0][23:0];
    r.east = v[1][23:0];
    r.down = v[2][23:0];
    r.last_out = p.last_point;
    return r;
  endfunction

  task automatic report(string what, logic [23:0] got, logic [23:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what,
             $signed(got), $signed(want), $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else begin
      if (point_valid && !point_stall) begin
        ned_expected.push_back(rotate_point(point));
        n_points++;
      end
      if (!point_valid || !point_stall) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          point_valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          point <= pending_points.pop_front();
          point_valid <= 1'b1;
          tx_gap <= tx_idle ? $urandom_range(0, 16) : 0;
        end else begin
          point_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    bit stall_next;
    int gap;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      stall_next = 1'b0;
      if (result_valid && !result_stall) begin
        n_results++;
        if (ned_expected.size() == 0) begin
          $display("unexpected transaction at %0t", $realtime);
          errors++;
        end else begin
          want = ned_expected.pop_front();
          if (result.north != want.north) report("north", result.north, want.north);
          if (result.east != want.east) report("east", result.east, want.east);
          if (result.down != want.down) report("down", result.down, want.down);
          if (result.last_out != want.last_out)
            report("last_out", result.last_out, want.last_out);
          if (want.north == OUT_MAX || want.north == OUT_MIN) n_sat++;
        end
        // hold off right after this transaction for the drawn number of cycles
        gap = rx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
          rx_gap <= gap - 1;
          stall_next = 1'b1;
        end else begin
          rx_gap <= 0;
        end
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        stall_next = 1'b1;
      end
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        stall_next = 1'b1;
      end
      result_stall <= stall_next;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((point_valid && !point_stall) || (result_valid && !result_stall) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(4 * idx);
    pwdata <= {16'($urandom_range(0, 65535)), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    n_writes++;
    if (idx < NUM_REGS) begin
      regs[idx] = val;
      if (idx < 3) rebuild_rotation();
    end
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || point_valid || ned_expected.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_len();
    case ($urandom_range(0, 5))
      0: return 24'($urandom());
      1: return 24'($signed($urandom_range(0, 40000)) - 20000);
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      3: return 24'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return 24'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(0, 51472)) - 25736);
      default: return 16'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  initial begin
    point_t p;
    logic [23:0] corners [6];
    logic [15:0] setting [NUM_REGS];
    corners = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h555555, 24'hAAAAAA};
    regs = '{16'sd0, 16'sd0, 16'sd0, LEV_FWD_RESET, LEV_LAT_RESET, LEV_VERT_RESET};
    rebuild_rotation();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset: field corners
    for (int k = 0; k < 24; k++) begin
      p.lateral_offset = corners[k % 6];
      p.vertical_offset = corners[(k / 6 + k) % 6];
      p.last_point = k[0];
      pending_points.push_back(p);
    end
    drain();

    for (int ph = 1; ph <= 14; ph++) begin
      case (ph)
        1: setting = '{16'sd25736, -16'sd25736, 16'sd25736, 16'h7FFF, 16'h8000, 16'h7FFF};
        2: setting = '{16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000};
        3: setting = '{16'sd12868, -16'sd12868, 16'sd12867, 16'h0000, 16'h0000, 16'h0000};
        4: setting = '{-16'sd12867, 16'sd12868, -16'sd12868, 16'hFFFF, 16'h0001, 16'hFFFF};
        default:
          for (int r = 0; r < NUM_REGS; r++)
            setting[r] = (r < 3) ? rand_angle() : 16'($urandom());
      endcase
      for (int r = 0; r < NUM_REGS; r++) write_reg(r, setting[r]);
      // writes past the register list must be ignored
      if (ph % 4 == 0) write_reg($urandom_range(NUM_REGS, 7), 16'($urandom()));
      tx_idle = (ph % 3 != 0);
      rx_idle = (ph % 4 != 1);
      if (ph == 5) begin
        tx_idle = 1'b0;
        rx_hold = 400;
      end
      for (int k = 0; k < 108; k++) begin
        p.lateral_offset = rand_len();
        p.vertical_offset = rand_len();
        p.last_point = ($urandom_range(0, 7) == 0);
        pending_points.push_back(p);
      end
      drain();
    end

    $display("covered %0d points, %0d results (%0d north saturated), %0d register writes",
             n_points, n_results, n_sat, n_writes);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
